// ----- hdl/pls_pkg.sv -----
// package for the positional list store
// widths, codes and the sequencer state type; no dependencies
package pls_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 3;

  localparam logic [1:0] OP_DUMP   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_LAST,
    S_INS_WRITE,
    S_DEL_SHIFT,
    S_DEL_LAST,
    S_SRCH,
    S_SRCH_LAST,
    S_DUMP,
    S_FINISH
  } state_t;

endpackage

// ----- hdl/pls_if.sv -----
// request and response channel interfaces of the positional list store
// depends on pls_pkg
interface pls_req_if
  import pls_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface pls_rsp_if
  import pls_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [VAL_W-1:0] element;
  logic [POS_W-1:0] found_position;
  logic             last;

  modport source (output valid, status, element, found_position, last, input ready);
  modport sink   (input valid, status, element, found_position, last, output ready);
endinterface

// ----- hdl/pls_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// read data holds while no read is enabled; no dependencies
module pls_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/positional_list_store.sv -----
// positional list store top level: sequencer around the element ram
// depends on pls_pkg, pls_if and pls_ram
//
// usage
//   req channel takes one word: opcode, 1-based position, value
//   rsp channel gives status, element, found_position, last
//   insert, delete and search give one word with last set
//   dump gives one word per element in order, last on the final one
//   an empty dump gives one word with status empty
// steps up to the load into the output register (count c, position p)
//   insert: moves elements c to p up a place, then writes; none at c + 1
//   delete: moves elements p + 1 to c down a place; none for p = c
//   search: reads elements in order until a match or past the last one
//   errors and empty dump: go straight to the load
//   dump: reads elements in order, one element per cycle while rsp ready
//   the next req word is taken in the cycle after the final load
// req is accepted whenever the sequencer is idle, also while a finished
// word still waits in the output register
// a stalled receiver holds the output register; the sequencer waits
// for it before loading the next word
// reset empties the list at once; the ram contents are not cleared
module positional_list_store
  import pls_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pls_req_if.sink   req,
  pls_rsp_if.source rsp
);

  state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] src;
  logic              rd_pend;
  logic              all_issued;
  logic [POS_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;
  logic [ST_W-1:0]   res_status;
  logic [POS_W-1:0]  res_fpos;

  logic              out_valid;
  logic [ST_W-1:0]   out_status;
  logic [VAL_W-1:0]  out_element;
  logic [POS_W-1:0]  out_fpos;
  logic              out_last;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  logic              acc, out_free, load, issue, match;
  logic [ADDR_W-1:0] last_addr, pos_addr;

  state_t            dec_next;
  logic [ST_W-1:0]   dec_status;
  logic [ADDR_W-1:0] dec_idx;
  logic              dec_shrink;

  pls_ram #(.DEPTH(CAPACITY), .WIDTH(VAL_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign match     = rd_pend && (ram_rdata == val_r);
  assign last_addr = ADDR_W'(count - 1'b1);
  assign pos_addr  = ADDR_W'(pos_r - 1'b1);

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.element        = out_element;
  assign rsp.found_position = out_fpos;
  assign rsp.last           = out_last;

  // request decode
  always_comb begin
    dec_next   = S_FINISH;
    dec_status = ST_OK;
    dec_idx    = '0;
    dec_shrink = 1'b0;
    case (req.opcode)
      OP_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          dec_status = ST_FULL;
        end else if (req.position == '0 ||
                     (CNT_W+1)'(req.position) > (CNT_W+1)'(count) + 1'b1) begin
          dec_status = ST_BADPOS;
        end else if ((CNT_W+1)'(req.position) == (CNT_W+1)'(count) + 1'b1) begin
          dec_next = S_INS_WRITE;
        end else begin
          dec_next = S_INS_SHIFT;
          dec_idx  = ADDR_W'(count - 1'b1);
        end
      end
      OP_DELETE: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else if (req.position == '0 || CNT_W'(req.position) > count) begin
          dec_status = ST_BADPOS;
        end else if (CNT_W'(req.position) == count) begin
          dec_shrink = 1'b1;
        end else begin
          dec_next = S_DEL_SHIFT;
          dec_idx  = ADDR_W'(req.position);
        end
      end
      OP_SEARCH: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_next = S_SRCH;
        end
      end
      default: begin
        if (count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_next = S_DUMP;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (acc) state_next = dec_next;
      S_INS_SHIFT: if (idx == pos_addr) state_next = S_INS_LAST;
      S_INS_LAST:  state_next = S_INS_WRITE;
      S_INS_WRITE: state_next = S_FINISH;
      S_DEL_SHIFT: if (idx == last_addr) state_next = S_DEL_LAST;
      S_DEL_LAST:  state_next = S_FINISH;
      S_SRCH: begin
        if (match) state_next = S_FINISH;
        else if (idx == last_addr) state_next = S_SRCH_LAST;
      end
      S_SRCH_LAST: state_next = S_FINISH;
      S_DUMP:      if (load && src == last_addr) state_next = S_IDLE;
      S_FINISH:    if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx;
    ram_we    = 1'b0;
    ram_waddr = src + 1'b1;
    ram_wdata = ram_rdata;
    load      = 1'b0;
    issue     = 1'b0;
    unique case (state)
      S_INS_SHIFT: begin
        ram_re = 1'b1;
        ram_we = rd_pend;
      end
      S_INS_LAST: ram_we = 1'b1;
      S_INS_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_addr;
        ram_wdata = val_r;
      end
      S_DEL_SHIFT: begin
        ram_re    = 1'b1;
        ram_we    = rd_pend;
        ram_waddr = src - 1'b1;
      end
      S_DEL_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = src - 1'b1;
      end
      S_SRCH: ram_re = !match;
      S_DUMP: begin
        load   = rd_pend && out_free;
        issue  = !all_issued && (!rd_pend || load);
        ram_re = issue;
      end
      S_FINISH: load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            pos_r      <= req.position;
            val_r      <= req.value;
            res_status <= dec_status;
            res_fpos   <= '0;
            idx        <= dec_idx;
            rd_pend    <= 1'b0;
            all_issued <= 1'b0;
            if (dec_shrink) count <= count - 1'b1;
          end
        end
        S_INS_SHIFT: begin
          src     <= idx;
          rd_pend <= 1'b1;
          idx     <= idx - 1'b1;
        end
        S_INS_WRITE: count <= count + 1'b1;
        S_DEL_SHIFT: begin
          src     <= idx;
          rd_pend <= 1'b1;
          idx     <= idx + 1'b1;
        end
        S_DEL_LAST: count <= count - 1'b1;
        S_SRCH: begin
          if (match) begin
            res_fpos <= POS_W'(src) + 1'b1;
          end else begin
            src     <= idx;
            rd_pend <= 1'b1;
            idx     <= idx + 1'b1;
          end
        end
        S_SRCH_LAST: begin
          if (match) res_fpos <= POS_W'(src) + 1'b1;
          else res_status <= ST_NOTFOUND;
        end
        S_DUMP: begin
          if (issue) begin
            src     <= idx;
            rd_pend <= 1'b1;
            if (idx == last_addr) all_issued <= 1'b1;
            else idx <= idx + 1'b1;
          end else if (load) begin
            rd_pend <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (load) begin
      if (state == S_DUMP) begin
        out_status  <= ST_OK;
        out_element <= ram_rdata;
        out_fpos    <= POS_W'(src) + 1'b1;
        out_last    <= (src == last_addr);
      end else begin
        out_status  <= res_status;
        out_element <= '0;
        out_fpos    <= res_fpos;
        out_last    <= 1'b1;
      end
    end
  end

endmodule
